[design/lri_pkg.sv]
package lri_pkg;

    // Field width of every coordinate, slope and offset.
    localparam int DATA_W        = 32;
    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEF = 16;
    // Depth of the queue between the front and the back part.
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    // Configuration register indexes.
    localparam logic CFG_INFINITY = 1'b0;
    localparam logic CFG_FLAT     = 1'b1;

    // How the back part treats one query.
    typedef enum logic [1:0] {
        KIND_UNDEF,
        KIND_FLAT,
        KIND_EDGE
    } t_kind;

    // One classified query, as it travels through the queue.
    typedef struct packed {
        t_kind       kind;
        logic [31:0] x_min;
        logic [31:0] y_min;
        logic [31:0] x_max;
        logic [31:0] y_max;
        logic [31:0] slope;
        logic [31:0] offset;
    } t_item;

    // Context carried alongside the divider stages.
    typedef struct packed {
        t_kind       kind;
        logic [31:0] x_min;
        logic [31:0] y_min;
        logic [31:0] x_max;
        logic [31:0] y_max;
        logic [31:0] offset;
        logic [31:0] y_left;
        logic [31:0] y_right;
        logic        neg_b;
        logic        neg_t;
        logic        nz_b;
        logic        nz_t;
    } t_ctx;

    // One result item.
    typedef struct packed {
        logic [31:0] second_y;
        logic [31:0] second_x;
        logic [31:0] first_y;
        logic [31:0] first_x;
        logic [1:0]  point_count;
        logic        found;
    } t_result;

    // Saturate a signed 64-bit value to the signed 32-bit range.
    function automatic logic [31:0] sat64(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > $signed({32'd0, S32_MAX})) begin
            r = S32_MAX;
        end else if (v < $signed({{32{1'b1}}, S32_MIN})) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[design/line_rect_intersection_unit.sv]
// Line versus rectangle intersection, signed fixed point with FRAC_BITS
// fraction bits.
// Queries arrive on the s_axis channel: one transfer carries the rectangle
// and the line y = slope*x + offset. Each query gives exactly one result on
// the m_axis channel: found, point count and two points, with unused point
// slots zero.
// Throughput is one query per cycle while the receiver does not stall.
// The two restoring dividers resolve one quotient bit per stage.
// A four-entry queue sits between the classifying front end and the
// arithmetic pipeline; when the receiver stalls, the pipeline holds, the
// queue fills and then s_axis_tready drops. Nothing is lost or repeated.
// The config port writes infinity_limit (index 0) and flat_limit (index 1);
// write them only while no query is in flight.
// Reset empties the queue and pipeline and restores infinity_limit to
// 0x7FFFFFFF and flat_limit to 1.
module line_rect_intersection_unit
    import lri_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // Fields from bit 0: x_min, y_min, x_max, y_max, slope, offset.
    input  logic [191:0]   s_axis_tdata,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // Fields from bit 0: found, point_count, first_x, first_y, second_x,
    // second_y, then zero padding.
    output logic [135:0]   m_axis_tdata,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [30:0]    i_cfg_wdata
);

    logic [30:0] r_inf_limit;
    logic [15:0] r_flat_limit;
    logic        w_push;
    logic        w_full;
    logic        w_pop;
    logic        w_q_valid;
    t_item       w_front_item;
    t_item       w_q_item;
    t_result     w_result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inf_limit  <= 31'h7FFF_FFFF;
            r_flat_limit <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INFINITY: r_inf_limit  <= i_cfg_wdata;
                CFG_FLAT:     r_flat_limit <= i_cfg_wdata[15:0];
                default:      r_inf_limit  <= r_inf_limit;
            endcase
        end
    end

    lri_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_s_data    (s_axis_tdata),
        .i_inf_limit (r_inf_limit),
        .i_flat_limit(r_flat_limit),
        .o_push      (w_push),
        .o_item      (w_front_item),
        .i_full      (w_full)
    );

    lri_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_item (w_front_item),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_item (w_q_item),
        .o_valid(w_q_valid)
    );

    lri_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_q_pop    (w_pop),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_out      (w_result)
    );

    assign m_axis_tdata = {5'd0, w_result};

    // A result is found exactly when it holds two points.
    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == 2'd2)))
        else $error("found flag disagrees with point count");

    // The point count never exceeds two.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:1] != 2'd3))
        else $error("point count out of range");

    // An unfilled second slot reads as zero.
    a_empty_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2:1] != 2'd2)
            |-> (m_axis_tdata[130:67] == 64'd0))
        else $error("unfilled point slot is not zero");

endmodule

[design/lri_front.sv]
module lri_front
    import lri_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    output logic                  o_s_ready,
    input  logic [6*DATA_W-1:0]   i_s_data,
    input  logic [30:0]           i_inf_limit,
    input  logic [15:0]           i_flat_limit,
    output logic                  o_push,
    output t_item                 o_item,
    input  logic                  i_full
);

    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic [32:0] w_mag;
    logic        w_undef;
    logic        w_flat;

    // Unpack the transfer and classify the line.
    always_comb begin
        n_item.x_min  = i_s_data[31:0];
        n_item.y_min  = i_s_data[63:32];
        n_item.x_max  = i_s_data[95:64];
        n_item.y_max  = i_s_data[127:96];
        n_item.slope  = i_s_data[159:128];
        n_item.offset = i_s_data[191:160];
        w_mag   = n_item.slope[31] ? (33'd0 - {1'b1, n_item.slope})
                                   : {1'b0, n_item.slope};
        w_undef = ($signed({n_item.slope[31], n_item.slope}) >= $signed({2'b00, i_inf_limit}))
               || ($signed({n_item.offset[31], n_item.offset}) >= $signed({2'b00, i_inf_limit}));
        w_flat  = w_mag < {17'd0, i_flat_limit};
        if (w_undef) begin
            n_item.kind = KIND_UNDEF;
        end else if (w_flat) begin
            n_item.kind = KIND_FLAT;
        end else begin
            n_item.kind = KIND_EDGE;
        end
    end

    assign o_push    = r_valid && !i_full;
    assign o_s_ready = !r_valid || !i_full;
    assign o_item    = r_item;

    // Holding register in front of the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_ready) begin
            r_valid <= i_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_ready && i_s_valid) begin
            r_item <= n_item;
        end
    end

endmodule

[design/lri_fifo.sv]
module lri_fifo
    import lri_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_valid
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_full  = r_count == (QPTR_W + 1)'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

[design/lri_back.sv]
module lri_back
    import lri_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_item   i_q_item,
    output logic    o_q_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out
);

    // Numerator magnitude and quotient width of the edge divisions.
    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int LAST  = NUM_W + 1;

    logic              r_v [LAST+1];
    t_ctx              r_ctx [LAST+1];
    logic [63:0]       r_prod_l;
    logic [63:0]       r_prod_r;
    logic [31:0]       r_den [NUM_W+1];
    logic [31:0]       r_rem_b [NUM_W+1];
    logic [31:0]       r_rem_t [NUM_W+1];
    logic [NUM_W-1:0]  r_nq_b [NUM_W+1];
    logic [NUM_W-1:0]  r_nq_t [NUM_W+1];
    logic [31:0]       r_xb;
    logic [31:0]       r_xt;
    logic              r_out_valid;
    t_result           r_out;

    logic              w_adv;
    t_ctx              n_ctx0;
    t_ctx              n_ctx1;
    logic [32:0]       w_diff_b;
    logic [32:0]       w_diff_t;
    logic [32:0]       w_mag_b;
    logic [32:0]       w_mag_t;
    logic [31:0]       n_den;
    logic [31:0]       n_rem_b [NUM_W];
    logic [31:0]       n_rem_t [NUM_W];
    logic [NUM_W-1:0]  n_nq_b [NUM_W];
    logic [NUM_W-1:0]  n_nq_t [NUM_W];
    t_result           n_out;

    // One restoring step: shift in a numerator bit, subtract when it fits.
    function automatic logic [32+NUM_W-1:0] div_step(input logic [31:0] rem,
                                                     input logic [NUM_W-1:0] nq,
                                                     input logic [31:0] den);
        logic [32:0] t;
        logic [32:0] d;
        logic        ge;
        logic [31:0] rem_n;
        t     = {rem, nq[NUM_W-1]};
        ge    = t >= {1'b0, den};
        d     = t - {1'b0, den};
        rem_n = ge ? d[31:0] : t[31:0];
        return {rem_n, nq[NUM_W-2:0], ge};
    endfunction

    // Saturate a quotient magnitude with its sign to 32 bits.
    function automatic logic [31:0] sat_q(input logic [NUM_W-1:0] q,
                                         input logic neg, input logic nz);
        logic [31:0] r;
        if (!nz) begin
            r = '0;
        end else if (!neg) begin
            r = (|q[NUM_W-1:31]) ? S32_MAX : q[31:0];
        end else if ((|q[NUM_W-1:32]) || (q[31] && (|q[30:0]))) begin
            r = S32_MIN;
        end else begin
            r = 32'd0 - q[31:0];
        end
        return r;
    endfunction

    // The whole back pipeline moves when the output register can take a result.
    assign w_adv       = !r_out_valid || i_out_ready;
    assign o_q_pop     = w_adv && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Entry stage: numerators, divisor magnitude and carried context.
    always_comb begin
        w_diff_b = {i_q_item.y_min[31], i_q_item.y_min}
                 - {i_q_item.offset[31], i_q_item.offset};
        w_diff_t = {i_q_item.y_max[31], i_q_item.y_max}
                 - {i_q_item.offset[31], i_q_item.offset};
        w_mag_b  = w_diff_b[32] ? (33'd0 - w_diff_b) : w_diff_b;
        w_mag_t  = w_diff_t[32] ? (33'd0 - w_diff_t) : w_diff_t;
        n_den    = i_q_item.slope[31] ? (32'd0 - i_q_item.slope) : i_q_item.slope;
        n_ctx0.kind    = i_q_item.kind;
        n_ctx0.x_min   = i_q_item.x_min;
        n_ctx0.y_min   = i_q_item.y_min;
        n_ctx0.x_max   = i_q_item.x_max;
        n_ctx0.y_max   = i_q_item.y_max;
        n_ctx0.offset  = i_q_item.offset;
        n_ctx0.y_left  = '0;
        n_ctx0.y_right = '0;
        n_ctx0.neg_b   = w_diff_b[32] ^ i_q_item.slope[31];
        n_ctx0.neg_t   = w_diff_t[32] ^ i_q_item.slope[31];
        n_ctx0.nz_b    = w_diff_b != '0;
        n_ctx0.nz_t    = w_diff_t != '0;
    end

    // Edge y values from the registered products: floor shift, add, saturate.
    always_comb begin
        n_ctx1 = r_ctx[0];
        n_ctx1.y_left  = sat64($signed($signed(r_prod_l) >>> FRAC_BITS)
                             + $signed({{32{r_ctx[0].offset[31]}}, r_ctx[0].offset}));
        n_ctx1.y_right = sat64($signed($signed(r_prod_r) >>> FRAC_BITS)
                             + $signed({{32{r_ctx[0].offset[31]}}, r_ctx[0].offset}));
    end

    // Divider steps, one quotient bit per stage for both edges.
    always_comb begin
        for (int k = 0; k < NUM_W; k++) begin
            {n_rem_b[k], n_nq_b[k]} = div_step(r_rem_b[k], r_nq_b[k], r_den[k]);
            {n_rem_t[k], n_nq_t[k]} = div_step(r_rem_t[k], r_nq_t[k], r_den[k]);
        end
    end

    // Edge case: the first pair of hits in the rectangle; flat: both x ends; undefined: none.
    always_comb begin
        t_ctx        c;
        logic [1:0]  n;
        logic [31:0] px0;
        logic [31:0] py0;
        logic [31:0] px1;
        logic [31:0] py1;
        c   = r_ctx[LAST];
        n   = '0;
        px0 = '0;
        py0 = '0;
        px1 = '0;
        py1 = '0;
        unique case (c.kind)
            KIND_UNDEF: begin
                n = 2'd0;
            end
            KIND_FLAT: begin
                px0 = c.x_min;
                py0 = c.offset;
                px1 = c.x_max;
                py1 = c.offset;
                n   = 2'd2;
            end
            KIND_EDGE: begin
                if ($signed(c.y_left) >= $signed(c.y_min)
                        && $signed(c.y_left) <= $signed(c.y_max)) begin
                    px0 = c.x_min;
                    py0 = c.y_left;
                    n   = 2'd1;
                end
                if ($signed(c.y_right) >= $signed(c.y_min)
                        && $signed(c.y_right) <= $signed(c.y_max)) begin
                    if (n == 2'd0) begin
                        px0 = c.x_max;
                        py0 = c.y_right;
                    end else begin
                        px1 = c.x_max;
                        py1 = c.y_right;
                    end
                    n = n + 2'd1;
                end
                if (n != 2'd2 && $signed(r_xb) >= $signed(c.x_min)
                        && $signed(r_xb) <= $signed(c.x_max)) begin
                    if (n == 2'd0) begin
                        px0 = r_xb;
                        py0 = c.y_min;
                    end else begin
                        px1 = r_xb;
                        py1 = c.y_min;
                    end
                    n = n + 2'd1;
                end
                if (n != 2'd2 && $signed(r_xt) >= $signed(c.x_min)
                        && $signed(r_xt) <= $signed(c.x_max)) begin
                    if (n == 2'd0) begin
                        px0 = r_xt;
                        py0 = c.y_max;
                    end else begin
                        px1 = r_xt;
                        py1 = c.y_max;
                    end
                    n = n + 2'd1;
                end
            end
            default: begin
                n = 2'd0;
            end
        endcase
        n_out.found       = n == 2'd2;
        n_out.point_count = n;
        n_out.first_x     = px0;
        n_out.first_y     = py0;
        n_out.second_x    = px1;
        n_out.second_y    = py1;
    end

    // Stage valid bits and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_v[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= o_q_pop;
            for (int k = 1; k <= LAST; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_out_valid <= r_v[LAST];
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ctx[0]   <= n_ctx0;
            r_prod_l   <= 64'($signed(i_q_item.slope) * $signed(i_q_item.x_min));
            r_prod_r   <= 64'($signed(i_q_item.slope) * $signed(i_q_item.x_max));
            r_den[0]   <= n_den;
            r_rem_b[0] <= '0;
            r_rem_t[0] <= '0;
            r_nq_b[0]  <= {w_mag_b[31:0], {FRAC_BITS{1'b0}}};
            r_nq_t[0]  <= {w_mag_t[31:0], {FRAC_BITS{1'b0}}};
            r_ctx[1]   <= n_ctx1;
            for (int k = 2; k <= LAST; k++) begin
                r_ctx[k] <= r_ctx[k-1];
            end
            for (int k = 1; k <= NUM_W; k++) begin
                r_den[k]   <= r_den[k-1];
                r_rem_b[k] <= n_rem_b[k-1];
                r_rem_t[k] <= n_rem_t[k-1];
                r_nq_b[k]  <= n_nq_b[k-1];
                r_nq_t[k]  <= n_nq_t[k-1];
            end
            r_xb <= sat_q(r_nq_b[NUM_W], r_ctx[NUM_W].neg_b, r_ctx[NUM_W].nz_b);
            r_xt <= sat_q(r_nq_t[NUM_W], r_ctx[NUM_W].neg_t, r_ctx[NUM_W].nz_t);
            if (r_v[LAST]) begin
                r_out <= n_out;
            end
        end
    end

endmodule

[tb/line_rect_intersection_checker.sv]
module line_rect_intersection_checker
    import lri_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [135:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [30:0]  i_cfg_wdata,
    output int           o_errors,
    output int           o_pending,
    output int           o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FRAC_BITS_DEF;

    logic [30:0] inf_lim;
    logic [15:0] flat_lim;
    t_result     answers[$];

    // Edge y: floored product plus offset, saturated.
    function automatic longint y_on_line(longint a, longint x, longint b);
        longint p;
        longint v;
        p = a * x;
        v = p >>> FB;
        v = v + b;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v;
    endfunction

    // Edge x: truncated quotient, saturated; zero slope saturates by sign.
    function automatic longint x_on_line(longint a, longint y, longint b);
        longint num;
        longint q;
        num = (y - b) * (64'sd1 <<< FB);
        if (a == 0) begin
            if (num > 0) return 64'sd2147483647;
            if (num < 0) return -64'sd2147483648;
            return 0;
        end
        q = num / a;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q;
    endfunction

    // Works out the crossing points for one query.
    function automatic t_result crossings(logic [191:0] d);
        longint xmn, ymn, xmx, ymx, a, b, mag, yl, yr, xb, xt;
        longint px[2];
        longint py[2];
        int n;
        t_result r;
        xmn = $signed(d[31:0]);
        ymn = $signed(d[63:32]);
        xmx = $signed(d[95:64]);
        ymx = $signed(d[127:96]);
        a = $signed(d[159:128]);
        b = $signed(d[191:160]);
        px = '{0, 0};
        py = '{0, 0};
        n = 0;
        mag = (a < 0) ? -a : a;
        if (a >= longint'(inf_lim) || b >= longint'(inf_lim)) begin
            n = 0;
        end else if (mag < longint'(flat_lim)) begin
            px[0] = xmn; py[0] = b; px[1] = xmx; py[1] = b; n = 2;
        end else begin
            yl = y_on_line(a, xmn, b);
            yr = y_on_line(a, xmx, b);
            xb = x_on_line(a, ymn, b);
            xt = x_on_line(a, ymx, b);
            if (yl >= ymn && yl <= ymx) begin px[n] = xmn; py[n] = yl; n++; end
            if (yr >= ymn && yr <= ymx) begin px[n] = xmx; py[n] = yr; n++; end
            if (n < 2 && xb >= xmn && xb <= xmx) begin px[n] = xb; py[n] = ymn; n++; end
            if (n < 2 && xt >= xmn && xt <= xmx) begin px[n] = xt; py[n] = ymx; n++; end
        end
        r.found = (n == 2);
        r.point_count = n[1:0];
        r.first_x = px[0][31:0];
        r.first_y = py[0][31:0];
        r.second_x = px[1][31:0];
        r.second_y = py[1][31:0];
        return r;
    endfunction

    assign o_pending = answers.size();

    // Track configuration, predict on each input transfer, compare on output.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            inf_lim <= 31'h7FFF_FFFF;
            flat_lim <= 16'd1;
            o_errors <= 0;
            o_results <= 0;
            answers.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_INFINITY) inf_lim <= i_cfg_wdata;
                else flat_lim <= i_cfg_wdata[15:0];
            end
            if (s_axis_tvalid && s_axis_tready) answers.push_back(crossings(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[130:0];
                o_results <= o_results + 1;
                if (answers.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = answers.pop_front();
                    if (want.found != got.found || want.point_count != got.point_count
                        || want.first_x != got.first_x || want.first_y != got.first_y
                        || want.second_x != got.second_x
                        || want.second_y != got.second_y) begin
                        $display("%0t: mismatch expected f=%0d n=%0d (%h,%h) (%h,%h)",
                            $time, want.found, want.point_count, want.first_x,
                            want.first_y, want.second_x, want.second_y);
                        $display("%0t:          actual   f=%0d n=%0d (%h,%h) (%h,%h)",
                            $time, got.found, got.point_count, got.first_x,
                            got.first_y, got.second_x, got.second_y);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/line_rect_intersection_unit_test.sv]
module line_rect_intersection_unit_test;
    import lri_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 60;
    localparam int LIMIT = 400000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_idx = CFG_INFINITY;
    logic [30:0]  i_cfg_wdata = '0;
    int           errors, pending, results;
    int           cycles = 0;
    int           hold_off = 0;
    bit           calm = 1'b0;
    int           sent = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    line_rect_intersection_unit dut (.*);

    line_rect_intersection_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .i_cfg_we, .i_cfg_idx,
        .i_cfg_wdata, .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("line_rect_intersection_unit_test: done, errors");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 26);
        end
    end

    // Sends one query, with a random gap before it. Valid stays high between
    // back-to-back queries; drain() drops it after the last one.
    task automatic send_query(logic [31:0] xmn, ymn, xmx, ymx, a, b);
        while (!calm && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, a, ymx, xmx, ymn, xmn};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    // Waits until the block has drained, then waits out the LATENCY margin.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [30:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Random value: mostly small coordinates, sometimes full range.
    function automatic logic [31:0] rnd_val();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(40 * 65536)) - 20 * 65536);
            2: return 32'($signed($urandom_range(4 * 65536)) - 2 * 65536);
            default: return 32'($signed($urandom_range(200)) - 100);
        endcase
    endfunction

    task automatic random_queries(int count);
        logic [31:0] xa, xb, ya, yb, a, b;
        logic [31:0] cx, cy;
        repeat (count) begin
            xa = rnd_val(); xb = rnd_val(); ya = rnd_val(); yb = rnd_val();
            // Mostly well-ordered rectangles, a few inverted.
            if ($urandom_range(9) != 0) begin
                if ($signed(xa) > $signed(xb)) begin cx = xa; xa = xb; xb = cx; end
                if ($signed(ya) > $signed(yb)) begin cy = ya; ya = yb; yb = cy; end
            end
            a = rnd_val();
            b = rnd_val();
            // Sometimes aim the line through a corner.
            if ($urandom_range(7) == 0) begin
                a = 32'h0001_0000;
                b = ya - xa;
            end
            send_query(xa, ya, xb, yb, a, b);
        end
    endtask

    initial begin
        logic [31:0] mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes and special cases at reset settings.
        send_query(0, 0, 32'h000A_0000, 32'h000A_0000, 32'h0001_0000, 0);   // corner hits
        send_query(0, 0, 32'h000A_0000, 32'h000A_0000, 0, 32'h0005_0000);   // flat line
        send_query(0, 0, 32'h000A_0000, 32'h000A_0000, 0, 32'h0100_0000);   // flat, off range
        send_query(0, 0, 10, 10, mx, 0);                                    // undefined slope
        send_query(0, 0, 10, 10, 32'h0001_0000, mx);                        // undefined offset
        send_query(mn, mn, mx, mx, 32'h0002_0000, 32'h0000_8000);
        send_query(mn, mn, mx, mx, mn, mn);
        send_query(mn, mn, mx, mx, 32'hFFFF_FFFF, mx - 1);
        send_query(mx, mx, mn, mn, 32'h0001_0000, 0);                       // inverted
        send_query(0, 0, 32'h000A_0000, 32'h000A_0000, 32'h0000_8000, 32'h0003_0000);
        send_query(0, 0, 32'h000A_0000, 32'h000A_0000, 32'hFFFF_0000, 32'h0014_0000);
        send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 0);
        drain();

        // Zero flat limit and small infinity limit.
        write_reg(CFG_FLAT, 31'd0);
        write_reg(CFG_INFINITY, 31'd0);
        send_query(0, 0, 10, 10, 0, 0);
        send_query(0, 0, 10, 10, mn, mn);
        drain();
        write_reg(CFG_INFINITY, 31'h7FFF_FFFF);
        send_query(0, 0, 32'h000A_0000, 32'h000A_0000, 0, 32'h0005_0000);
        send_query(0, 0, 32'h000A_0000, 32'h000A_0000, 0, 0);
        send_query(0, 0, 32'h000A_0000, 32'h000A_0000, 0, 32'hFFFF_0000);
        drain();
        write_reg(CFG_FLAT, 31'hFFFF);
        send_query(0, 0, 10, 10, 32'h0000_FFFE, 3);
        send_query(0, 0, 10, 10, 32'hFFFF_0001, 3);
        send_query(0, 0, 10, 10, 32'h0000_FFFF, 3);
        drain();

        // Random phases over several settings.
        write_reg(CFG_FLAT, 31'd1);
        random_queries(150);
        // Sender pauses until everything is back.
        drain();
        write_reg(CFG_INFINITY, 31'h0100_0000);
        write_reg(CFG_FLAT, 31'd300);
        hold_off = 200;
        random_queries(150);
        drain();
        calm = 1'b1;
        write_reg(CFG_INFINITY, 31'h7FFF_FFFF);
        write_reg(CFG_FLAT, 31'd0);
        random_queries(100);
        calm = 1'b0;
        drain();
        write_reg(CFG_FLAT, 31'd1);
        random_queries(200);
        drain();

        $display("Sent %0d queries over five register settings, %0d results checked.",
            sent, results);
        if (errors == 0 && pending == 0) begin
            $display("line_rect_intersection_unit_test: done, clean");
        end else begin
            $display("line_rect_intersection_unit_test: done, errors");
        end
        $finish;
    end
endmodule
